>>> design/fat16_cluster_chain_offset_translator_core_assert.svh
// Assertion macros for the checker file of the cluster chain translator.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FAT16_CLUSTER_CHAIN_OFFSET_TRANSLATOR_CORE_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_OFFSET_TRANSLATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define FCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fct assertion failed");

// Next-cycle implication.
`define FCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fct assertion failed");

`endif

>>> design/fct_pkg.sv
// Package for the FAT16 cluster chain translator: table size, status and
// register codes, entry classification. No dependencies.
package fct_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned PADDR_W       = 5;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_END      = 3'd1,
    ST_BAD      = 3'd2,
    ST_RESERVED = 3'd3,
    ST_FREE     = 3'd4,
    ST_RANGE    = 3'd5,
    ST_HOPS     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    REG_SECTOR_SHIFT  = 3'd0,
    REG_CLUSTER_SHIFT = 3'd1,
    REG_RSV_SECS      = 3'd2,
    REG_FAT_NUM       = 3'd3,
    REG_FAT_SECS      = 3'd4,
    REG_ROOT_ENTS     = 3'd5
  } reg_idx_e;

  function automatic logic in_table(input logic [15:0] v);
    in_table = ({1'b0, v} < 17'(TABLE_ENTRIES));
  endfunction

  // start cluster must be a data cluster that the table holds
  function automatic logic cluster_usable(input logic [15:0] c);
    cluster_usable = (c >= 16'h0002) && (c <= 16'hFFEF) && in_table(c);
  endfunction

  // status of an entry read during a hop; ST_OK is a usable link
  function automatic status_e classify(input logic [15:0] e);
    status_e s;
    s = ST_OK;
    if (e == 16'h0000) begin
      s = ST_FREE;
    end else if (e == 16'h0001) begin
      s = ST_RESERVED;
    end else if (e inside {[16'hFFF8:16'hFFFF]}) begin
      s = ST_END;
    end else if (e == 16'hFFF7) begin
      s = ST_BAD;
    end else if (e inside {[16'hFFF0:16'hFFF6]}) begin
      s = ST_RESERVED;
    end else if (!in_table(e)) begin
      s = ST_RANGE;
    end
    classify = s;
  endfunction

endpackage

>>> design/fat16_cluster_chain_offset_translator_core.sv
// FAT16 cluster chain translator: allocation table memory, chain walker and
// address sequencer around one shared 36-bit adder. Depends on fct_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | sink      | in_valid_i/in_ready_o  | kind, cluster_index, entry_value,
//           |           |                        | byte_offset
//   out     | source    | out_valid_o/out_ready_i| status, found_cluster, disk_byte_address
//   cfg     | APB slave | psel/penable, pready=1 | 6 registers at 4*i
//
// A load goes straight from idle to the output state; a translate walks each hop as a
// table read state and a classify state, then makes five passes through the shared adder.
// in_ready_o is high only while the sequencer idles; the output register lets
// a new transaction in while the previous result waits, and a result that finds
// it still full holds the sequencer in its last state. Reset clears control and
// config; the table is not cleared and holds garbage until loaded.
module fat16_cluster_chain_offset_translator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [15:0]                 cluster_index_i,
  input  logic [15:0]                 entry_value_i,
  input  logic [31:0]                 byte_offset_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [15:0]                 found_cluster_o,
  output logic [35:0]                 disk_byte_address_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fct_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned IDX_W = fct_pkg::IDX_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CHECK = 10'b00_0000_0010,
    S_READ  = 10'b00_0000_0100,
    S_HOP   = 10'b00_0000_1000,
    S_ROOT  = 10'b00_0001_0000,
    S_RDIR  = 10'b00_0010_0000,
    S_SECS  = 10'b00_0100_0000,
    S_CLUS  = 10'b00_1000_0000,
    S_ADDR  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  // ---------------- configuration registers ----------------
  logic [3:0]  ss_q;   // sector shift
  logic [2:0]  cs_q;   // cluster shift
  logic [15:0] rsv_q;
  logic [2:0]  fc_q;
  logic [15:0] spf_q;
  logic [15:0] rde_q;

  logic                cfg_we;
  fct_pkg::reg_idx_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = fct_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q  <= 4'd9;
      cs_q  <= 3'd2;
      rsv_q <= 16'd1;
      fc_q  <= 3'd2;
      spf_q <= 16'd32;
      rde_q <= 16'd512;
    end else if (cfg_we) begin
      case (cfg_idx)
        fct_pkg::REG_SECTOR_SHIFT:  ss_q  <= pwdata[3:0];
        fct_pkg::REG_CLUSTER_SHIFT: cs_q  <= pwdata[2:0];
        fct_pkg::REG_RSV_SECS:      rsv_q <= pwdata[15:0];
        fct_pkg::REG_FAT_NUM:       fc_q  <= pwdata[2:0];
        fct_pkg::REG_FAT_SECS:      spf_q <= pwdata[15:0];
        fct_pkg::REG_ROOT_ENTS:     rde_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fct_pkg::REG_SECTOR_SHIFT:  prdata = {28'd0, ss_q};
      fct_pkg::REG_CLUSTER_SHIFT: prdata = {29'd0, cs_q};
      fct_pkg::REG_RSV_SECS:      prdata = {16'd0, rsv_q};
      fct_pkg::REG_FAT_NUM:       prdata = {29'd0, fc_q};
      fct_pkg::REG_FAT_SECS:      prdata = {16'd0, spf_q};
      fct_pkg::REG_ROOT_ENTS:     prdata = {16'd0, rde_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------- sequencer state ----------------
  state_e            state_q, state_d;
  fct_pkg::status_e  st_q, st_d;
  logic [15:0]       cur_q, cur_d;      // current cluster
  logic [31:0]       off_q;             // file byte offset
  logic [IDX_W-1:0]  hop_q, hop_d;      // hops still to walk
  logic [35:0]       acc_q, acc_d;      // address accumulator
  logic [21:0]       t_q, t_d;          // root bytes plus one sector less one byte
  logic [15:0]       rd_q;              // registered table read

  logic              out_valid_q;
  fct_pkg::status_e  out_st_q;
  logic [15:0]       out_cl_q;
  logic [35:0]       out_addr_q;

  logic in_acc, out_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // ---------------- allocation table ----------------
  logic [15:0] mem_q [fct_pkg::TABLE_ENTRIES];
  logic        tbl_we, tbl_re;

  assign tbl_we = in_acc && !kind_i && fct_pkg::in_table(cluster_index_i);
  assign tbl_re = (state_q == S_READ);

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      mem_q[cluster_index_i[IDX_W-1:0]] <= entry_value_i;
    end
    if (tbl_re) begin
      rd_q <= mem_q[cur_q[IDX_W-1:0]];
    end
  end

  // ---------------- shared adder and its operands ----------------
  logic [4:0]  tot_shift;
  logic [31:0] hops_full;
  logic [31:0] in_clus;     // offset bits inside the cluster
  logic [35:0] sec_mask;
  logic [18:0] root_prod;
  logic [15:0] cur_m2;
  logic [35:0] op_a, op_b, sum;
  logic        too_many;
  fct_pkg::status_e hop_st;

  assign tot_shift = {1'b0, ss_q} + {2'b00, cs_q};
  assign hops_full = off_q >> tot_shift;
  assign too_many  = (hops_full >> IDX_W) != 32'd0;
  assign in_clus   = off_q & ~({32{1'b1}} << tot_shift);
  assign sec_mask  = ~({36{1'b1}} << ss_q);
  assign root_prod = 19'(fc_q) * 19'(spf_q);
  assign cur_m2    = cur_q - 16'd2;
  assign hop_st    = fct_pkg::classify(rd_q);

  always_comb begin
    op_a = acc_q;
    op_b = 36'd0;
    case (state_q)
      S_ROOT: begin
        op_a = {20'd0, rsv_q};
        op_b = {17'd0, root_prod};
      end
      S_RDIR: begin
        op_a = {15'd0, rde_q, 5'd0};
        op_b = sec_mask;
      end
      S_SECS: op_b = {14'd0, t_q >> ss_q};
      S_CLUS: op_b = {20'd0, cur_m2} << cs_q;
      S_ADDR: begin
        op_a = acc_q << ss_q;
        op_b = {4'd0, in_clus};
      end
      default: ;
    endcase
  end

  assign sum = op_a + op_b;

  // ---------------- next-state logic ----------------
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cur_d   = cur_q;
    hop_d   = hop_q;
    acc_d   = acc_q;
    t_d     = t_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cur_d = cluster_index_i;
          acc_d = 36'd0;
          st_d  = fct_pkg::ST_OK;
          if (kind_i) begin
            state_d = S_CHECK;
          end else begin
            // load result carries zero cluster and address
            cur_d = 16'd0;
            if (!fct_pkg::in_table(cluster_index_i)) st_d = fct_pkg::ST_RANGE;
            state_d = S_OUT;
          end
        end
      end
      S_CHECK: begin
        hop_d = hops_full[IDX_W-1:0];
        if (!fct_pkg::cluster_usable(cur_q)) begin
          st_d    = fct_pkg::ST_RANGE;
          cur_d   = 16'd0;
          state_d = S_OUT;
        end else if (too_many) begin
          st_d    = fct_pkg::ST_HOPS;
          cur_d   = 16'd0;
          state_d = S_OUT;
        end else if (hops_full[IDX_W-1:0] == '0) begin
          state_d = S_ROOT;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_HOP;
      S_HOP: begin
        if (hop_st != fct_pkg::ST_OK) begin
          st_d    = hop_st;
          cur_d   = 16'd0;
          state_d = S_OUT;
        end else begin
          cur_d   = rd_q;
          hop_d   = hop_q - IDX_W'(1);
          state_d = (hop_q == IDX_W'(1)) ? S_ROOT : S_READ;
        end
      end
      S_ROOT: begin
        acc_d   = sum;
        state_d = S_RDIR;
      end
      S_RDIR: begin
        t_d     = sum[21:0];
        state_d = S_SECS;
      end
      S_SECS: begin
        acc_d   = sum;
        state_d = S_CLUS;
      end
      S_CLUS: begin
        acc_d   = sum;
        state_d = S_ADDR;
      end
      S_ADDR: begin
        acc_d   = sum;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    cur_q <= cur_d;
    hop_q <= hop_d;
    acc_q <= acc_d;
    t_q   <= t_d;
    if (in_acc) off_q <= byte_offset_i;
    if (state_q == S_OUT && out_free) begin
      out_st_q   <= st_q;
      out_cl_q   <= cur_q;
      out_addr_q <= acc_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_st_q;
  assign found_cluster_o     = out_cl_q;
  assign disk_byte_address_o = out_addr_q;

endmodule

>>> design/fct_checker.sv
// Port-level checker for the cluster chain translator, bound to the top.
// Depends on fct_pkg and the assertion macro header.
`include "fat16_cluster_chain_offset_translator_core_assert.svh"

module fct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [15:0] found_cluster_o,
  input logic [35:0] disk_byte_address_o
);

  logic        out_stall;
  logic        out_fail;
  logic        out_ok;
  logic        fail_zero;
  logic        ok_clus;
  logic [54:0] out_word;

  assign out_stall = out_valid_o && !out_ready_i;
  assign out_fail  = out_valid_o && (status_o != fct_pkg::ST_OK);
  assign out_ok    = out_valid_o && (status_o == fct_pkg::ST_OK);
  assign fail_zero = (found_cluster_o == 16'd0) && (disk_byte_address_o == 36'd0);
  assign ok_clus   = (found_cluster_o == 16'd0) || (found_cluster_o >= 16'd2);
  assign out_word  = {status_o, found_cluster_o, disk_byte_address_o};

  // a stalled result keeps its payload
  `FCT_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_word))

  // one transaction at a time: the sequencer leaves idle on every accept
  `FCT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // failures carry zero cluster and address
  `FCT_ASSERT_NOW(a_fail_zero, out_fail, fail_zero)

  // a successful translate ends on a data cluster; loads report cluster zero
  `FCT_ASSERT_NOW(a_ok_cluster, out_ok, ok_clus)

endmodule

bind fat16_cluster_chain_offset_translator_core fct_checker u_fct_checker (.*);
